// File: rtl/nxdn_voice_frame_assembler_unit_macros.svh
// ----------------------------------------------------------------------------
// NXDN voice frame assembler - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NXDN_VOICE_FRAME_ASSEMBLER_UNIT_MACROS_SVH
`define NXDN_VOICE_FRAME_ASSEMBLER_UNIT_MACROS_SVH

// same-cycle implication
`define NVFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NVFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nvfa_pkg.sv
// ----------------------------------------------------------------------------
// NXDN voice frame assembler - package
// Frame layout constants, queue entry type and shared helper functions.
// ----------------------------------------------------------------------------
package nvfa_pkg;

    // frame geometry
    localparam int FRAME_LEN   = 43;
    localparam int FRAME_BITS  = FRAME_LEN * 8;
    localparam int VOICE_W     = 49;
    localparam int ID_W        = 16;
    localparam int HDR_W       = 112;
    localparam int PAYLOAD_W   = 224;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_DEI = 2'd2;

    // fixed field values
    localparam logic [39:0] FRAME_TAG     = 40'h4E58_444E_44;   // "NXDND"
    localparam logic [7:0]  MSG_CALL      = 8'h01;
    localparam logic [7:0]  MSG_RELEASE   = 8'h08;
    localparam logic [7:0]  HDR_BYTE2     = 8'h20;
    localparam logic [7:0]  FLAG_CALL     = 8'h05;
    localparam logic [7:0]  FLAG_RELEASE  = 8'h09;
    localparam logic [7:0]  FLAG_VOICE    = 8'h01;
    localparam logic [7:0]  LICH_HEADER   = 8'h81;
    localparam logic [7:0]  LICH_VOICE    = 8'hAC;
    localparam logic [7:0]  SACCH_FIRST_HDR = 8'h01;
    localparam logic [5:0]  SACCH_FIRST_LOW = 6'h01;
    localparam logic [17:0] SACCH_IDLE    = 18'h04000;          // 0x10 0x00 0x00, top 18 bits
    localparam logic [5:0]  CRC_INIT      = 6'h3F;
    localparam logic [5:0]  CRC_POLY      = 6'h27;

    // voice bit reorder: output bit k takes input bit PERM49[k], bit 0 sent first
    localparam logic [5:0] PERM49 [VOICE_W] = '{
        6'd0,  6'd3,  6'd6,  6'd9,  6'd12, 6'd15, 6'd18, 6'd21, 6'd24, 6'd27,
        6'd30, 6'd33, 6'd36, 6'd39, 6'd41, 6'd43, 6'd45, 6'd47,
        6'd1,  6'd4,  6'd7,  6'd10, 6'd13, 6'd16, 6'd19, 6'd22, 6'd25, 6'd28,
        6'd31, 6'd34, 6'd37, 6'd40, 6'd42, 6'd44, 6'd46, 6'd48,
        6'd2,  6'd5,  6'd8,  6'd11, 6'd14, 6'd17, 6'd20, 6'd23, 6'd26, 6'd29,
        6'd32, 6'd35, 6'd38
    };

    // one classified request as handed from front to back
    typedef struct packed {
        logic                 hdr;
        logic                 eoc;
        logic [31:0]          sacch;
        logic [VOICE_W-1:0]   voice_a;
        logic [VOICE_W-1:0]   voice_b;
        logic [VOICE_W-1:0]   voice_c;
        logic [VOICE_W-1:0]   voice_d;
    } entry_t;

    // bit reorder of one voice frame (pure wiring)
    function automatic logic [VOICE_W-1:0] permute(input logic [VOICE_W-1:0] v);
        logic [VOICE_W-1:0] r;
        r = '0;
        for (int k = 0; k < VOICE_W; k++)
        begin
            r[VOICE_W-1-k] = v[VOICE_W-1-int'(PERM49[k])];
        end
        return r;
    endfunction

    // 14-byte layer-3 call header, byte 0 in the top bits
    function automatic logic [HDR_W-1:0] make_header(
        input logic [7:0]      msgtype,
        input logic [ID_W-1:0] src,
        input logic [ID_W-1:0] dst
    );
        return {msgtype, 8'h00, HDR_BYTE2, src, dst, 56'h0};
    endfunction

    // CRC-6 over up to eight message bits, MSB of data first
    function automatic logic [5:0] crc_step(
        input logic [5:0] crc_in,
        input logic [7:0] data,
        input logic [3:0] nbits
    );
        logic [5:0] c;
        logic       fb;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            if (i < int'(nbits))
            begin
                fb = data[7-i] ^ c[5];
                c  = {c[4:0], 1'b0};
                if (fb)
                begin
                    c = c ^ CRC_POLY;
                end
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/nxdn_voice_frame_assembler_unit.sv
// ----------------------------------------------------------------------------
// NXDN voice frame assembler - top level
// Turns each request of four voice frames into one 43-byte network frame.
// ----------------------------------------------------------------------------
// Each request (end_of_call plus four 49-bit voice frames) produces one
// 43-byte frame on the byte channel, last_byte marking byte 42. The byte
// channel carries one byte per cycle while out_ready is high, and frames
// follow each other with no gap while requests are queued and out_ready
// stays high. The front end captures a request and runs a 4-step CRC-6 on
// the SACCH, then hands entries to a QUEUE_DEPTH-entry queue, so new
// requests are taken while an earlier frame is still going out; sustained
// throughput is set by the byte-wide output.
// Configuration writes are taken in any cycle (cfg_ready is always high) and
// must only be made while no frame is in flight.
// ----------------------------------------------------------------------------
module nxdn_voice_frame_assembler_unit #(
    parameter int QUEUE_DEPTH = nvfa_pkg::QUEUE_DEPTH     // 2 or more
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nvfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nvfa_pkg::ID_W-1:0]        cfg_data,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             end_of_call,
    input  logic [nvfa_pkg::VOICE_W-1:0]     voice_a,
    input  logic [nvfa_pkg::VOICE_W-1:0]     voice_b,
    input  logic [nvfa_pkg::VOICE_W-1:0]     voice_c,
    input  logic [nvfa_pkg::VOICE_W-1:0]     voice_d,
    // byte channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       frame_byte,
    output logic                             last_byte
);

    localparam int ENTRY_W = $bits(nvfa_pkg::entry_t);

    logic [nvfa_pkg::ID_W-1:0] source_id_reg;
    logic [nvfa_pkg::ID_W-1:0] dest_id_reg;
    logic                      deint_reg;

    logic                 fq_valid, fq_ready;
    nvfa_pkg::entry_t     fq_data;
    logic                 qb_valid, qb_ready;
    logic [ENTRY_W-1:0]   qb_bits;
    nvfa_pkg::entry_t     qb_data;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_id_reg <= '0;
            dest_id_reg   <= '0;
            deint_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                nvfa_pkg::REG_SOURCE_ID: source_id_reg <= cfg_data;
                nvfa_pkg::REG_DEST_ID:   dest_id_reg   <= cfg_data;
                nvfa_pkg::REG_VOICE_DEI: deint_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // request classification and SACCH build
    nvfa_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .source_id          (source_id_reg),
        .dest_id            (dest_id_reg),
        .voice_deinterleave (deint_reg),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .end_of_call        (end_of_call),
        .voice_a            (voice_a),
        .voice_b            (voice_b),
        .voice_c            (voice_c),
        .voice_d            (voice_d),
        .q_valid            (fq_valid),
        .q_ready            (fq_ready),
        .q_data             (fq_data)
    );

    // decoupling queue
    nvfa_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_bits)
    );

    assign qb_data = nvfa_pkg::entry_t'(qb_bits);

    // frame build and byte output
    nvfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .source_id  (source_id_reg),
        .dest_id    (dest_id_reg),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_data     (qb_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule

// File: rtl/nvfa_front.sv
// ----------------------------------------------------------------------------
// NXDN voice frame assembler - front end
// Accepts a request, classifies it as header or voice frame, tracks call
// state, builds the SACCH and runs its CRC-6, then pushes one queue entry.
// ----------------------------------------------------------------------------
module nvfa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic [nvfa_pkg::ID_W-1:0]     source_id,
    input  logic [nvfa_pkg::ID_W-1:0]     dest_id,
    input  logic                          voice_deinterleave,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          end_of_call,
    input  logic [nvfa_pkg::VOICE_W-1:0]  voice_a,
    input  logic [nvfa_pkg::VOICE_W-1:0]  voice_b,
    input  logic [nvfa_pkg::VOICE_W-1:0]  voice_c,
    input  logic [nvfa_pkg::VOICE_W-1:0]  voice_d,
    // queue side
    output logic                          q_valid,
    input  logic                          q_ready,
    output nvfa_pkg::entry_t              q_data
);

    localparam logic [1:0] STEP_LAST = 2'd3;

    logic       busy_reg, busy_next;
    logic       crc_done_reg, crc_done_next;
    logic [1:0] step_reg, step_next;
    logic       started_reg, started_next;
    logic [1:0] phase_reg, phase_next;

    logic [25:0] msg_reg;
    logic [5:0]  crc_reg;
    logic        hdr_reg;
    logic        eoc_reg;
    logic [nvfa_pkg::VOICE_W-1:0] va_reg, vb_reg, vc_reg, vd_reg;

    logic        accept;
    logic        push;
    logic        is_hdr;
    logic [nvfa_pkg::HDR_W-1:0] call_hdr;
    logic [17:0] hdr_slice;
    logic [7:0]  sacch_first;
    logic [17:0] sacch_data;
    logic [7:0]  crc_bits;
    logic [3:0]  crc_nbits;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign q_valid  = busy_reg && crc_done_reg;
    assign push     = q_valid && q_ready;

    // classification and SACCH contents for the incoming request
    assign is_hdr   = !started_reg || end_of_call;
    assign call_hdr = nvfa_pkg::make_header(nvfa_pkg::MSG_CALL, source_id, dest_id);

    always_comb
    begin
        unique case (phase_reg)
            2'd0: hdr_slice = call_hdr[111:94];
            2'd1: hdr_slice = call_hdr[93:76];
            2'd2: hdr_slice = call_hdr[75:58];
            2'd3: hdr_slice = call_hdr[57:40];
        endcase
    end

    assign sacch_first = is_hdr ? nvfa_pkg::SACCH_FIRST_HDR
                                : {~phase_reg, nvfa_pkg::SACCH_FIRST_LOW};
    assign sacch_data  = is_hdr ? nvfa_pkg::SACCH_IDLE : hdr_slice;

    // CRC bit group per step: 8, 8, 8, then the last 2
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                crc_bits  = msg_reg[25:18];
                crc_nbits = 4'd8;
            end
            2'd1:
            begin
                crc_bits  = msg_reg[17:10];
                crc_nbits = 4'd8;
            end
            2'd2:
            begin
                crc_bits  = msg_reg[9:2];
                crc_nbits = 4'd8;
            end
            2'd3:
            begin
                crc_bits  = {msg_reg[1:0], 6'b0};
                crc_nbits = 4'd2;
            end
        endcase
    end

    // control next state
    always_comb
    begin
        busy_next     = busy_reg;
        crc_done_next = crc_done_reg;
        step_next     = step_reg;
        started_next  = started_reg;
        phase_next    = phase_reg;
        if (accept)
        begin
            busy_next     = 1'b1;
            crc_done_next = 1'b0;
            step_next     = 2'd0;
            if (end_of_call)
            begin
                started_next = 1'b0;
                phase_next   = 2'd0;
            end
            else
            begin
                started_next = 1'b1;
                phase_next   = phase_reg + 2'd1;
            end
        end
        else if (busy_reg && !crc_done_reg)
        begin
            step_next = step_reg + 2'd1;
            if (step_reg == STEP_LAST)
            begin
                crc_done_next = 1'b1;
            end
        end
        else if (push)
        begin
            busy_next     = 1'b0;
            crc_done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            crc_done_reg <= 1'b0;
            step_reg     <= 2'd0;
            started_reg  <= 1'b0;
            phase_reg    <= 2'd0;
        end
        else
        begin
            busy_reg     <= busy_next;
            crc_done_reg <= crc_done_next;
            step_reg     <= step_next;
            started_reg  <= started_next;
            phase_reg    <= phase_next;
        end
    end

    // request capture and CRC datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            msg_reg <= {sacch_first, sacch_data};
            crc_reg <= nvfa_pkg::CRC_INIT;
            hdr_reg <= is_hdr;
            eoc_reg <= end_of_call;
            va_reg  <= voice_deinterleave ? nvfa_pkg::permute(voice_a) : voice_a;
            vb_reg  <= voice_deinterleave ? nvfa_pkg::permute(voice_b) : voice_b;
            vc_reg  <= voice_deinterleave ? nvfa_pkg::permute(voice_c) : voice_c;
            vd_reg  <= voice_deinterleave ? nvfa_pkg::permute(voice_d) : voice_d;
        end
        else if (busy_reg && !crc_done_reg)
        begin
            crc_reg <= nvfa_pkg::crc_step(crc_reg, crc_bits, crc_nbits);
        end
    end

    assign q_data.hdr     = hdr_reg;
    assign q_data.eoc     = eoc_reg;
    assign q_data.sacch   = {msg_reg, crc_reg};
    assign q_data.voice_a = va_reg;
    assign q_data.voice_b = vb_reg;
    assign q_data.voice_c = vc_reg;
    assign q_data.voice_d = vd_reg;

endmodule

// File: rtl/nvfa_queue.sv
// ----------------------------------------------------------------------------
// NXDN voice frame assembler - entry queue
// Small register FIFO between front end and back end.
// ----------------------------------------------------------------------------
`include "nxdn_voice_frame_assembler_unit_macros.svh"

module nvfa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2     // 2 or more
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    `NVFA_ASSERT_NOW(a_q_count_range, 1'b1, count_reg <= CNT_FULL, "queue count overflow")
    `NVFA_ASSERT_NEXT(a_q_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not rise on push")

endmodule

// File: rtl/nvfa_back.sv
// ----------------------------------------------------------------------------
// NXDN voice frame assembler - back end
// Builds the 43-byte frame from a queue entry and shifts it out, one byte
// per cycle unless out_ready stalls it, through a registered output stage.
// ----------------------------------------------------------------------------
`include "nxdn_voice_frame_assembler_unit_macros.svh"

module nvfa_back (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic [nvfa_pkg::ID_W-1:0]  source_id,
    input  logic [nvfa_pkg::ID_W-1:0]  dest_id,
    // queue side
    input  logic                       q_valid,
    output logic                       q_ready,
    input  nvfa_pkg::entry_t           q_data,
    // byte channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 frame_byte,
    output logic                       last_byte
);

    localparam int CNT_W = $clog2(nvfa_pkg::FRAME_LEN);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(nvfa_pkg::FRAME_LEN - 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic [nvfa_pkg::FRAME_BITS-1:0] shift_reg;

    logic adv;
    logic emit;
    logic pop;
    logic at_last;

    logic [7:0]                       flag_byte;
    logic [7:0]                       lich_byte;
    logic [nvfa_pkg::HDR_W-1:0]       hdr_vec;
    logic [nvfa_pkg::PAYLOAD_W-1:0]   voice_payload;
    logic [nvfa_pkg::PAYLOAD_W-1:0]   payload;
    logic [nvfa_pkg::FRAME_BITS-1:0]  frame;

    assign adv     = !out_valid_reg || out_ready;
    assign emit    = busy_reg && adv;
    assign at_last = (cnt_reg == LAST_IDX);
    assign q_ready = !busy_reg || (adv && at_last);
    assign pop     = q_valid && q_ready;

    // frame assembly from the head entry
    assign flag_byte = q_data.hdr ? (q_data.eoc ? nvfa_pkg::FLAG_RELEASE : nvfa_pkg::FLAG_CALL)
                                  : nvfa_pkg::FLAG_VOICE;
    assign lich_byte = q_data.hdr ? nvfa_pkg::LICH_HEADER : nvfa_pkg::LICH_VOICE;
    assign hdr_vec   = nvfa_pkg::make_header(
                           q_data.eoc ? nvfa_pkg::MSG_RELEASE : nvfa_pkg::MSG_CALL,
                           source_id, dest_id);

    // voice frames at bits 120, 169, 232, 281; last bits repeated at 226 and 330
    assign voice_payload = {q_data.voice_a, q_data.voice_b, 8'h00, q_data.voice_b[0], 5'b0,
                            q_data.voice_c, q_data.voice_d, q_data.voice_d[0], 13'b0};
    assign payload       = q_data.hdr ? {hdr_vec, hdr_vec} : voice_payload;
    assign frame         = {nvfa_pkg::FRAME_TAG, source_id, dest_id, flag_byte, lich_byte,
                            q_data.sacch, payload};

    // sequencing
    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            cnt_next       = cnt_reg + 1'b1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // byte shifter and output stage
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= shift_reg[nvfa_pkg::FRAME_BITS-1 -: 8];
            out_last_reg <= at_last;
        end
        if (pop)
        begin
            shift_reg <= frame;
        end
        else if (emit)
        begin
            shift_reg <= {shift_reg[nvfa_pkg::FRAME_BITS-9:0], 8'h00};
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign last_byte  = out_last_reg;

    `NVFA_ASSERT_NEXT(a_bk_load, pop, busy_reg && (cnt_reg == '0), "frame load did not restart count")
    `NVFA_ASSERT_NOW(a_bk_cnt, busy_reg, cnt_reg <= LAST_IDX, "byte count past frame end")
    `NVFA_ASSERT_NEXT(a_bk_done, emit && at_last && !pop, !busy_reg, "back end busy after final byte")

endmodule

// File: dv/nxdn_voice_frame_assembler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NXDN voice frame assembler - unit testbench
// A queue-fed driver offers requests and a clocked monitor checks every frame
// byte against a behavioral frame builder kept in step with the block's call
// state and register settings. Directed requests come first, then random
// calls under three idle mixes, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module nxdn_voice_frame_assembler_unit_test;

    localparam int  CLK_HALF      = 4;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  SETTLE_CYCLES = 64;      // front end plus one full frame
    localparam int  LONG_HOLD     = 600;
    localparam int  RAND_PER_MIX  = 51;
    localparam int  BYTES_PER_FRM = 43;

    // register index with no register behind it
    localparam logic [nvfa_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // frame field values
    localparam logic [39:0] TAG_NXDND    = 40'h4E_58_44_4E_44;
    localparam logic [7:0]  TYPE_CALL    = 8'h01;
    localparam logic [7:0]  TYPE_RELEASE = 8'h08;
    localparam logic [7:0]  HDR_OPTION   = 8'h20;
    localparam logic [7:0]  FLG_CALL     = 8'h05;
    localparam logic [7:0]  FLG_RELEASE  = 8'h09;
    localparam logic [7:0]  FLG_VOICE    = 8'h01;
    localparam logic [7:0]  LICH_HDR     = 8'h81;
    localparam logic [7:0]  LICH_VCH     = 8'hAC;
    localparam logic [7:0]  SACCH_HDR    = 8'h01;
    localparam logic [17:0] SACCH_IDLE_D = {8'h10, 10'h000};
    localparam logic [5:0]  SACCH_SEED   = 6'h3F;
    localparam logic [5:0]  SACCH_POLY   = 6'h27;

    typedef logic [nvfa_pkg::VOICE_W-1:0] voice_t;

    typedef struct packed {
        logic   eoc;
        voice_t va;
        voice_t vb;
        voice_t vc;
        voice_t vd;
    } voice_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [nvfa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [nvfa_pkg::ID_W-1:0]      cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic                           end_of_call;
    voice_t                         voice_a;
    voice_t                         voice_b;
    voice_t                         voice_c;
    voice_t                         voice_d;
    logic                           out_valid;
    logic                           out_ready;
    logic [7:0]                     frame_byte;
    logic                           last_byte;

    // request and frame byte stores
    voice_req_t  pending_reqs[$];
    frame_byte_t frame_bytes_due[$];

    int issued_cnt;
    int accepted_cnt;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_asked;
    int hold_done;
    int hold_left;
    int cycle_count;
    int mismatches;
    int bytes_checked;
    int reg_writes;
    int n_call_hdr;
    int n_voice;
    int n_release;

    // shadow registers and call state of the frame builder
    logic [nvfa_pkg::ID_W-1:0] cur_source_id;
    logic [nvfa_pkg::ID_W-1:0] cur_dest_id;
    logic                      cur_deinterleave;
    logic [1:0]                call_phase_m;
    logic                      call_live;

    nxdn_voice_frame_assembler_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .end_of_call (end_of_call),
        .voice_a     (voice_a),
        .voice_b     (voice_b),
        .voice_c     (voice_c),
        .voice_d     (voice_d),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte  (frame_byte),
        .last_byte   (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // source position of transmitted bit k under voice deinterleave
    function automatic int deint_source(input int k);
        if (k < 14)
        begin
            return 3 * k;
        end
        if (k < 18)
        begin
            return 41 + 2 * (k - 14);
        end
        if (k < 32)
        begin
            return 3 * (k - 18) + 1;
        end
        if (k < 36)
        begin
            return 42 + 2 * (k - 32);
        end
        return 3 * (k - 36) + 2;
    endfunction

    function automatic voice_t reorder_voice(input voice_t v);
        voice_t r;
        r = '0;
        for (int k = 0; k < nvfa_pkg::VOICE_W; k++)
        begin
            r[nvfa_pkg::VOICE_W-1-k] = v[nvfa_pkg::VOICE_W-1-deint_source(k)];
        end
        return r;
    endfunction

    // SACCH: first byte, 18 data bits, CRC-6 over the 26 bits before it
    function automatic logic [31:0] sacch_word(input logic [7:0] first,
                                              input logic [17:0] data);
        logic [25:0] msg;
        logic [5:0]  crc;
        logic        fb;
        msg = {first, data};
        crc = SACCH_SEED;
        for (int i = 25; i >= 0; i--)
        begin
            fb  = msg[i] ^ crc[5];
            crc = {crc[4:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ SACCH_POLY;
            end
        end
        return {msg, crc};
    endfunction

    // build the 43-byte frame for one request and queue its bytes
    function automatic void assemble_frame(input voice_req_t rq);
        logic [0:nvfa_pkg::FRAME_BITS-1] fr;
        logic [nvfa_pkg::HDR_W-1:0]      hdr;
        voice_t                          v[4];
        fr = '0;
        fr[0 +: 40]  = TAG_NXDND;
        fr[40 +: 16] = cur_source_id;
        fr[56 +: 16] = cur_dest_id;
        if (!call_live || rq.eoc)
        begin
            hdr = {(rq.eoc ? TYPE_RELEASE : TYPE_CALL), 8'h00, HDR_OPTION,
                   cur_source_id, cur_dest_id, 56'h0};
            fr[72 +: 8]   = rq.eoc ? FLG_RELEASE : FLG_CALL;
            fr[80 +: 8]   = LICH_HDR;
            fr[88 +: 32]  = sacch_word(SACCH_HDR, SACCH_IDLE_D);
            fr[120 +: nvfa_pkg::HDR_W] = hdr;
            fr[232 +: nvfa_pkg::HDR_W] = hdr;
            if (rq.eoc)
            begin
                n_release++;
            end
            else
            begin
                n_call_hdr++;
            end
        end
        else
        begin
            hdr = {TYPE_CALL, 8'h00, HDR_OPTION, cur_source_id, cur_dest_id, 56'h0};
            fr[72 +: 8]  = FLG_VOICE;
            fr[80 +: 8]  = LICH_VCH;
            fr[88 +: 32] = sacch_word({2'd3 - call_phase_m, 6'h01},
                                      hdr[nvfa_pkg::HDR_W-1-18*int'(call_phase_m) -: 18]);
            v[0] = rq.va;
            v[1] = rq.vb;
            v[2] = rq.vc;
            v[3] = rq.vd;
            for (int i = 0; i < 4; i++)
            begin
                if (cur_deinterleave)
                begin
                    v[i] = reorder_voice(v[i]);
                end
            end
            fr[120 +: nvfa_pkg::VOICE_W] = v[0];
            fr[169 +: nvfa_pkg::VOICE_W] = v[1];
            fr[226]                      = v[1][0];
            fr[232 +: nvfa_pkg::VOICE_W] = v[2];
            fr[281 +: nvfa_pkg::VOICE_W] = v[3];
            fr[330]                      = v[3][0];
            n_voice++;
        end

        // call state moves on after every request
        if (rq.eoc)
        begin
            call_phase_m = 2'd0;
            call_live    = 1'b0;
        end
        else
        begin
            call_phase_m = call_phase_m + 2'd1;
            call_live    = 1'b1;
        end

        for (int k = 0; k < BYTES_PER_FRM; k++)
        begin
            frame_bytes_due.push_back({fr[8*k +: 8], k == BYTES_PER_FRM - 1});
        end
    endfunction

    function automatic voice_t rand_voice();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return w[nvfa_pkg::VOICE_W-1:0];
        endcase
    endfunction

    task automatic queue_request(input logic eoc, input voice_t a, input voice_t b,
                                 input voice_t c, input voice_t d);
        pending_reqs.push_back({eoc, a, b, c, d});
    endtask

    // one register write, shadow updated on the accepting edge
    task automatic write_reg(input logic [nvfa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nvfa_pkg::ID_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            nvfa_pkg::REG_SOURCE_ID: cur_source_id    = val;
            nvfa_pkg::REG_DEST_ID:   cur_dest_id      = val;
            nvfa_pkg::REG_VOICE_DEI: cur_deinterleave = val[0];
            default:                 ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || issued_cnt != accepted_cnt ||
               frame_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // request driver: a new request only once the previous one was taken
    always @(negedge clk)
    begin
        voice_req_t rq;
        if (rst_n && issued_cnt == accepted_cnt)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                rq = pending_reqs.pop_front();
                in_valid    <= 1'b1;
                end_of_call <= rq.eoc;
                voice_a     <= rq.va;
                voice_b     <= rq.vb;
                voice_c     <= rq.vc;
                voice_d     <= rq.vd;
                issued_cnt++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // request acceptance feeds the frame builder
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            assemble_frame({end_of_call, voice_a, voice_b, voice_c, voice_d});
            accepted_cnt++;
        end
    end

    // byte receiver with random stalls and an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_asked != hold_done)
        begin
            hold_done = hold_asked;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // byte monitor
    always @(posedge clk)
    begin
        frame_byte_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected byte 0x%02h last=%0b", $time, frame_byte, last_byte);
                mismatches++;
            end
            else
            begin
                due = frame_bytes_due.pop_front();
                if (frame_byte !== due.data)
                begin
                    $display("%0t: frame_byte expected 0x%02h actual 0x%02h",
                             $time, due.data, frame_byte);
                    mismatches++;
                end
                if (last_byte !== due.last)
                begin
                    $display("%0t: last_byte expected %0b actual %0b",
                             $time, due.last, last_byte);
                    mismatches++;
                end
                bytes_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d bytes still due",
                 cycle_count, frame_bytes_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        end_of_call = 1'b0;
        voice_a     = '0;
        voice_b     = '0;
        voice_c     = '0;
        voice_d     = '0;
        out_ready   = 1'b0;
        issued_cnt    = 0;
        accepted_cnt  = 0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        hold_asked    = 0;
        hold_done     = 0;
        hold_left     = 0;
        cycle_count   = 0;
        mismatches    = 0;
        bytes_checked = 0;
        reg_writes    = 0;
        n_call_hdr    = 0;
        n_voice       = 0;
        n_release     = 0;
        cur_source_id    = '0;
        cur_dest_id      = '0;
        cur_deinterleave = 1'b0;
        call_phase_m     = 2'd0;
        call_live        = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ids at opposite extremes, deinterleave off via a masked value
        write_reg(nvfa_pkg::REG_SOURCE_ID, 16'hFFFF);
        write_reg(nvfa_pkg::REG_DEST_ID, 16'h0000);
        write_reg(nvfa_pkg::REG_VOICE_DEI, 16'hFFFE);
        write_reg(REG_SPARE, 16'hFFFF);

        // call start, voice extremes, last-bit copies, phase wrap, releases
        queue_request(1'b0, '1, '1, '1, '1);
        queue_request(1'b0, '1, '1, '1, '1);
        queue_request(1'b0, '0, '0, '0, '0);
        queue_request(1'b0, 49'h1, 49'h1, 49'h1, 49'h1);
        queue_request(1'b0, 49'h1_0000_0000_0000, 49'h1_0000_0000_0000,
                      49'h1_0000_0000_0000, 49'h1_0000_0000_0000);
        queue_request(1'b0, 49'h1_5555_5555_5555, 49'h0_AAAA_AAAA_AAAA,
                      49'h1_5555_5555_5555, 49'h0_AAAA_AAAA_AAAA);
        queue_request(1'b1, '1, '1, '1, '1);
        queue_request(1'b1, '0, '0, '0, '0);
        queue_request(1'b0, '0, '0, '0, '0);
        queue_request(1'b0, rand_voice(), rand_voice(), rand_voice(), rand_voice());
        wait_drained();

        // ids swapped, deinterleave on, walking single bits
        write_reg(nvfa_pkg::REG_SOURCE_ID, 16'h0000);
        write_reg(nvfa_pkg::REG_DEST_ID, 16'hFFFF);
        write_reg(nvfa_pkg::REG_VOICE_DEI, 16'h0001);
        write_reg(REG_SPARE, 16'h0000);
        queue_request(1'b0, '0, '0, '0, '0);
        queue_request(1'b0, 49'h1, 49'h2, 49'h4, 49'h8);
        queue_request(1'b0, 49'h1_0000_0000_0000, 49'h0_8000_0000_0000,
                      49'h0_0000_0100_0000, 49'h0_0000_0000_0100);
        queue_request(1'b0, 49'h0_0000_0100_0000, 49'h1_0000_0000_0000,
                      49'h1, 49'h0_0400_0000_0000);
        queue_request(1'b0, '1, '0, '1, '0);
        queue_request(1'b0, '1, '1, '1, '1);
        queue_request(1'b1, '1, '1, '1, '1);
        wait_drained();

        // random calls under three idle mixes
        for (int mix = 0; mix < 3; mix++)
        begin
            send_idle_pct = (mix == 0) ? 8 : (mix == 1) ? 85 : 0;
            recv_idle_pct = (mix == 0) ? 85 : (mix == 1) ? 8 : 0;
            write_reg(nvfa_pkg::REG_SOURCE_ID, 16'($urandom));
            write_reg(nvfa_pkg::REG_DEST_ID, 16'($urandom));
            write_reg(nvfa_pkg::REG_VOICE_DEI, 16'($urandom));
            if (mix == 0)
            begin
                hold_asked++;
            end
            for (int n = 0; n < RAND_PER_MIX; n++)
            begin
                queue_request($urandom_range(0, 7) == 0, rand_voice(), rand_voice(),
                              rand_voice(), rand_voice());
                // sender pause halfway until the block has drained
                if (n == RAND_PER_MIX / 2)
                begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        $display("run covered %0d requests: %0d call headers, %0d voice, %0d release frames",
                 accepted_cnt, n_call_hdr, n_voice, n_release);
        $display("%0d frame bytes checked, %0d register writes, %0d mismatches",
                 bytes_checked, reg_writes, mismatches);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
